// ===== sv/fctg_pkg.sv =====
// shared types, constants and reset tables for the four-channel compare tick generator
package fctg_pkg;

  localparam int CHANNELS     = 4;
  localparam int COUNT_BITS   = 16;
  localparam int REG_BITS     = 16;
  localparam int CH_BITS      = 2;
  localparam int OUT_BITS     = 4;
  localparam int CFG_IDX_BITS = 3;

  // register map: prescale first, then one interval per channel
  localparam int REG_PRESCALE      = 0;
  localparam int REG_INTERVAL_BASE = 1;
  localparam int INTERVAL_REGS     = 4;

  localparam logic [REG_BITS-1:0] PRESCALE_RESET = 16'd1440;

  typedef enum logic {
    CMD_TICK       = 1'b0,
    CMD_FLAG_WRITE = 1'b1
  } fctg_cmd_e;

  typedef struct packed {
    logic [REG_BITS-1:0]                prescale;
    logic [CHANNELS-1:0][REG_BITS-1:0]  interval;
  } fctg_cfg_t;

  typedef struct packed {
    logic [OUT_BITS-1:0] flags;
    logic [OUT_BITS-1:0] fired;
  } fctg_result_t;

  function automatic logic [REG_BITS-1:0] interval_reset(input int ch);
    logic [REG_BITS-1:0] v;
    unique case (ch)
      0:       v = 16'd50000;
      1:       v = 16'd5000;
      2:       v = 16'd500;
      default: v = 16'd50;
    endcase
    return v;
  endfunction

endpackage

// ===== sv/four_channel_compare_tick_generator_unit.sv =====
// top level of the four-channel compare tick generator
// Each transaction is a tick or a flag write and yields one result, registered in the
// input register and then, through the compare logic, in the result register; a new
// transaction is taken every cycle while the output is being drained (one transaction
// per cycle); prescaler, counter and compare values update as each one advances.
// Configuration writes are never stalled and must be made while idle.
module four_channel_compare_tick_generator_unit import fctg_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [REG_BITS-1:0]     cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    cmd_i,
  input  logic [CH_BITS-1:0]      channel_i,
  input  logic                    flag_value_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [OUT_BITS-1:0]     flags_o,
  output logic [OUT_BITS-1:0]     fired_o
);

  fctg_cfg_t    cfg;
  fctg_result_t res;
  logic         res_valid;
  logic         res_ready;

  fctg_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  fctg_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cmd_i        (cmd_i),
    .channel_i    (channel_i),
    .flag_value_i (flag_value_i),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_o        (res)
  );

  fctg_result_reg u_res (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_ready_o (res_ready),
    .res_i       (res),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .flags_o     (flags_o),
    .fired_o     (fired_o)
  );

endmodule

// ===== sv/fctg_cfg_regs.sv =====
// configuration register file: prescale and per-channel intervals
module fctg_cfg_regs import fctg_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [REG_BITS-1:0]     cfg_data_i,
  output fctg_cfg_t               cfg_o
);

  fctg_cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      if (cfg_index_i == CFG_IDX_BITS'(REG_PRESCALE)) begin
        cfg_d.prescale = cfg_data_i;
      end
      for (int i = 0; i < CHANNELS; i++) begin
        if (i < INTERVAL_REGS && cfg_index_i == CFG_IDX_BITS'(REG_INTERVAL_BASE + i)) begin
          cfg_d.interval[i] = cfg_data_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prescale <= PRESCALE_RESET;
      for (int i = 0; i < CHANNELS; i++) begin
        cfg_q.interval[i] <= interval_reset(i);
      end
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== sv/fctg_core.sv =====
// input register, prescaler, main counter and compare channels
module fctg_core import fctg_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fctg_cfg_t          cfg_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               cmd_i,
  input  logic [CH_BITS-1:0] channel_i,
  input  logic               flag_value_i,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output fctg_result_t       res_o
);

  logic               s1_valid_q;
  fctg_cmd_e          s1_cmd_q;
  logic [CH_BITS-1:0] s1_ch_q;
  logic               s1_val_q;

  logic [REG_BITS-1:0]   pre_cnt_q, pre_cnt_d;
  logic [COUNT_BITS-1:0] main_cnt_q, main_cnt_d;
  logic [COUNT_BITS-1:0] cmp_q [CHANNELS];
  logic [COUNT_BITS-1:0] cmp_d [CHANNELS];
  logic [CHANNELS-1:0]   flag_q, flag_d;
  logic [CHANNELS-1:0]   hit;
  logic                  step;
  logic                  advance;

  assign advance     = s1_valid_q && res_ready_i;
  assign in_ready_o  = !s1_valid_q || res_ready_i;
  assign res_valid_o = s1_valid_q;

  always_comb begin
    step       = (s1_cmd_q == CMD_TICK) && (pre_cnt_q >= cfg_i.prescale);
    pre_cnt_d  = pre_cnt_q;
    main_cnt_d = main_cnt_q;
    if (s1_cmd_q == CMD_TICK) begin
      if (step) begin
        pre_cnt_d  = '0;
        main_cnt_d = COUNT_BITS'(main_cnt_q + 1'b1);
      end else begin
        pre_cnt_d  = REG_BITS'(pre_cnt_q + 1'b1);
      end
    end
    flag_d = flag_q;
    for (int i = 0; i < CHANNELS; i++) begin
      // compare against the value the counter steps onto
      hit[i]   = step && (main_cnt_d == cmp_q[i]);
      cmp_d[i] = hit[i] ? COUNT_BITS'(cmp_q[i] + COUNT_BITS'(cfg_i.interval[i])) : cmp_q[i];
      if (hit[i]) begin
        flag_d[i] = 1'b1;
      end
      if (s1_cmd_q == CMD_FLAG_WRITE && int'(s1_ch_q) == i) begin
        flag_d[i] = s1_val_q;
      end
    end
    res_o = '0;
    for (int j = 0; j < OUT_BITS; j++) begin
      if (j < CHANNELS) begin
        res_o.flags[j] = flag_d[j];
        res_o.fired[j] = hit[j];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_cmd_q <= fctg_cmd_e'(cmd_i);
      s1_ch_q  <= channel_i;
      s1_val_q <= flag_value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_cnt_q  <= '0;
      main_cnt_q <= '0;
      flag_q     <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        cmp_q[i] <= COUNT_BITS'(interval_reset(i));
      end
    end else if (advance) begin
      pre_cnt_q  <= pre_cnt_d;
      main_cnt_q <= main_cnt_d;
      flag_q     <= flag_d;
      for (int i = 0; i < CHANNELS; i++) begin
        cmp_q[i] <= cmp_d[i];
      end
    end
  end

endmodule

// ===== sv/fctg_result_reg.sv =====
// result register between the core and the output channel
module fctg_result_reg import fctg_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                res_valid_i,
  output logic                res_ready_o,
  input  fctg_result_t        res_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [OUT_BITS-1:0] flags_o,
  output logic [OUT_BITS-1:0] fired_o
);

  logic         valid_q;
  fctg_result_t data_q;

  assign res_ready_o = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign flags_o     = data_q.flags;
  assign fired_o     = data_q.fired;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (res_ready_o) begin
      valid_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready_o && res_valid_i) begin
      data_q <= res_i;
    end
  end

endmodule

// ===== sv/fctg_checker.sv =====
// port-level checker for the compare tick generator and its bind
module fctg_checker import fctg_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input logic [OUT_BITS-1:0] flags_o,
  input logic [OUT_BITS-1:0] fired_o
);

  // a channel that fired has its flag set in the same result
  a_fired_sets_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((fired_o & ~flags_o) == '0))
    else $error("fired channel without flag");

  // input only backs up when the result register is full and stalled
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled without output stall");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(flags_o) && $stable(fired_o)))
    else $error("stalled result changed");

  // no result while in reset
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("result valid during reset");

endmodule

bind four_channel_compare_tick_generator_unit fctg_checker u_fctg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .flags_o     (flags_o),
  .fired_o     (fired_o)
);

// ===== verif/four_channel_compare_tick_generator_unit_tb.sv =====
// self-checking testbench for the four-channel compare tick generator
`timescale 1ns / 100ps

module four_channel_compare_tick_generator_unit_tb;
  import fctg_pkg::*;

  // holds the expected flags/fired pairs and the timer state that produces them
  class compare_tick_scoreboard;
    localparam logic [REG_BITS-1:0] INTERVAL_AT_RESET [CHANNELS] = '{
      16'd50000, 16'd5000, 16'd500, 16'd50
    };

    logic [REG_BITS-1:0]   prescale_reg;
    logic [REG_BITS-1:0]   interval_reg [CHANNELS];
    logic [REG_BITS-1:0]   prescale_cnt;
    logic [COUNT_BITS-1:0] main_cnt;
    logic [COUNT_BITS-1:0] compare_val [CHANNELS];
    logic [CHANNELS-1:0]   event_flag;
    fctg_result_t          expected_q [$];
    int                    mismatches;
    int                    results_checked;
    int                    fire_events;
    int                    counter_wraps;

    function new();
      prescale_reg = PRESCALE_RESET;
      prescale_cnt = '0;
      main_cnt     = '0;
      event_flag   = '0;
      for (int i = 0; i < CHANNELS; i++) begin
        interval_reg[i] = INTERVAL_AT_RESET[i];
        compare_val[i]  = INTERVAL_AT_RESET[i];
      end
      mismatches      = 0;
      results_checked = 0;
      fire_events     = 0;
      counter_wraps   = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void write_register(int idx, logic [REG_BITS-1:0] data);
      if (idx == REG_PRESCALE) begin
        prescale_reg = data;
      end else if (idx >= REG_INTERVAL_BASE && idx < REG_INTERVAL_BASE + INTERVAL_REGS) begin
        interval_reg[idx - REG_INTERVAL_BASE] = data;
      end
    endfunction

    function void note_accepted_item(fctg_cmd_e cmd, logic [CH_BITS-1:0] ch, logic val);
      fctg_result_t        r;
      logic [CHANNELS-1:0] fired;
      fired = '0;
      if (cmd == CMD_FLAG_WRITE) begin
        event_flag[ch] = val;
      end else if (prescale_cnt >= prescale_reg) begin
        // greater-or-equal so a lowered prescale still wraps on the next tick
        prescale_cnt = '0;
        main_cnt     = main_cnt + 1'b1;
        if (main_cnt == '0) counter_wraps++;
        for (int i = 0; i < CHANNELS; i++) begin
          if (main_cnt == compare_val[i]) begin
            event_flag[i]  = 1'b1;
            compare_val[i] = compare_val[i] + interval_reg[i];
            fired[i]       = 1'b1;
            fire_events++;
          end
        end
      end else begin
        prescale_cnt = prescale_cnt + 1'b1;
      end
      r.flags = event_flag;
      r.fired = fired;
      expected_q.push_back(r);
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_result(logic [OUT_BITS-1:0] flags, logic [OUT_BITS-1:0] fired);
      fctg_result_t exp_r;
      if (expected_q.size() == 0) begin
        report($sformatf("result flags=%h fired=%h with no transaction pending", flags, fired));
      end else begin
        exp_r = expected_q.pop_front();
        results_checked++;
        if (flags !== exp_r.flags)
          report($sformatf("flags got %h want %h", flags, exp_r.flags));
        if (fired !== exp_r.fired)
          report($sformatf("fired got %h want %h", fired, exp_r.fired));
      end
    endtask
  endclass

  logic                    clk_i;
  logic                    rst_ni;
  logic                    cfg_valid_i;
  logic                    cfg_ready_o;
  logic [CFG_IDX_BITS-1:0] cfg_index_i;
  logic [REG_BITS-1:0]     cfg_data_i;
  logic                    in_valid_i;
  logic                    in_ready_o;
  logic                    cmd_i;
  logic [CH_BITS-1:0]      channel_i;
  logic                    flag_value_i;
  logic                    out_valid_o;
  logic                    out_ready_i;
  logic [OUT_BITS-1:0]     flags_o;
  logic [OUT_BITS-1:0]     fired_o;

  compare_tick_scoreboard sb;
  int sender_idle_pct;
  int receiver_stall_pct;
  int items_sent;
  int cfg_writes;

  four_channel_compare_tick_generator_unit i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cmd_i        (cmd_i),
    .channel_i    (channel_i),
    .flag_value_i (flag_value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .flags_o      (flags_o),
    .fired_o      (fired_o)
  );

  always #5 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    out_ready_i = ($urandom_range(99) >= receiver_stall_pct);
  end

  // results are checked before the same edge's input transaction is noted
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) sb.check_result(flags_o, fired_o);
      if (in_valid_i && in_ready_o)
        sb.note_accepted_item(fctg_cmd_e'(cmd_i), channel_i, flag_value_i);
    end
  end

  task automatic send_item(input fctg_cmd_e cmd, input logic [CH_BITS-1:0] ch,
                           input logic val);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   = 1'b1;
    cmd_i        = cmd;
    channel_i    = ch;
    flag_value_i = val;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    items_sent++;
  endtask

  task automatic send_random_item(input int flag_write_pct);
    fctg_cmd_e cmd;
    cmd = ($urandom_range(99) < flag_write_pct) ? CMD_FLAG_WRITE : CMD_TICK;
    send_item(cmd, CH_BITS'($urandom_range(3)), 1'($urandom_range(1)));
  endtask

  task automatic wait_drained();
    in_valid_i = 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  task automatic write_register(input int idx, input logic [REG_BITS-1:0] data);
    cfg_valid_i = 1'b1;
    cfg_index_i = CFG_IDX_BITS'(idx);
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_register(idx, data);
    cfg_writes++;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  function automatic logic [REG_BITS-1:0] pick_interval();
    logic [REG_BITS-1:0] v;
    case ($urandom_range(7))
      0:       v = '0;
      1:       v = 16'd1;
      2:       v = 16'hFFFF;
      3:       v = REG_BITS'($urandom_range(16'hFFFF));
      default: v = REG_BITS'($urandom_range(2, 12));
    endcase
    return v;
  endfunction

  function automatic logic [REG_BITS-1:0] pick_prescale();
    logic [REG_BITS-1:0] v;
    case ($urandom_range(11))
      0:       v = 16'hFFFF;
      1:       v = REG_BITS'($urandom_range(8, 40));
      default: v = REG_BITS'($urandom_range(0, 3));
    endcase
    return v;
  endfunction

  initial begin
    int idle_sender [4];
    int idle_receiver [4];
    idle_sender   = '{0, 51, 0, 10};
    idle_receiver = '{0, 0, 51, 10};

    sb                 = new();
    clk_i              = 1'b0;
    rst_ni             = 1'b0;
    cfg_valid_i        = 1'b0;
    cfg_index_i        = '0;
    cfg_data_i         = '0;
    in_valid_i         = 1'b0;
    cmd_i              = CMD_TICK;
    channel_i          = '0;
    flag_value_i       = 1'b0;
    out_ready_i        = 1'b1;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    items_sent         = 0;
    cfg_writes         = 0;

    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: flag writes both ways, ticks at reset prescale
    for (int c = 0; c < CHANNELS; c++) send_item(CMD_FLAG_WRITE, CH_BITS'(c), 1'b1);
    send_item(CMD_TICK, 2'd3, 1'b1);
    send_item(CMD_TICK, 2'd0, 1'b0);
    for (int c = 0; c < CHANNELS; c++) send_item(CMD_FLAG_WRITE, CH_BITS'(c), 1'b0);
    wait_drained();

    // extreme and small values in every register, plus the unmapped indexes
    write_register(REG_PRESCALE, 16'hFFFF);
    write_register(REG_INTERVAL_BASE + 0, 16'd0);
    write_register(REG_INTERVAL_BASE + 1, 16'd1);
    write_register(REG_INTERVAL_BASE + 2, 16'hFFFF);
    write_register(REG_INTERVAL_BASE + 3, 16'd2);
    for (int k = 0; k < 3; k++) write_register(REG_INTERVAL_BASE + INTERVAL_REGS + k, 16'hFFFF);
    repeat (3) send_item(CMD_TICK, 2'd1, 1'b0);
    wait_drained();

    write_register(REG_PRESCALE, 16'd0);
    repeat (5) send_item(CMD_TICK, 2'd2, 1'b1);
    wait_drained();
    write_register(REG_PRESCALE, 16'd4);
    repeat (3) send_item(CMD_TICK, 2'd0, 1'b0);
    wait_drained();
    // prescale dropped under the running prescaler count
    write_register(REG_PRESCALE, 16'd1);
    repeat (2) send_item(CMD_TICK, 2'd3, 1'b0);
    wait_drained();

    // random phases cycling through the idling modes
    for (int p = 0; p < 12; p++) begin
      wait_drained();
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      write_register(REG_PRESCALE, pick_prescale());
      for (int c = 0; c < CHANNELS; c++)
        if (p < 4 || $urandom_range(1)) write_register(REG_INTERVAL_BASE + c, pick_interval());
      if ($urandom_range(2) == 0)
        write_register(REG_INTERVAL_BASE + INTERVAL_REGS + $urandom_range(2),
                       REG_BITS'($urandom()));
      sender_idle_pct    = idle_sender[p % 4];
      receiver_stall_pct = idle_receiver[p % 4];
      repeat (100) send_random_item(15);
    end

    // full step rate with extreme intervals
    wait_drained();
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    write_register(REG_PRESCALE, 16'd0);
    write_register(REG_INTERVAL_BASE + 0, 16'hFFFF);
    write_register(REG_INTERVAL_BASE + 1, 16'd0);
    write_register(REG_INTERVAL_BASE + 2, 16'd1);
    write_register(REG_INTERVAL_BASE + 3, 16'd4);
    repeat (100) send_random_item(1);

    wait_drained();
    repeat (5) @(negedge clk_i);
    $display("covered %0d transactions, %0d results checked, %0d channel events, %0d counter wraps",
             items_sent, sb.results_checked, sb.fire_events, sb.counter_wraps);
    $display("%0d register writes across directed, random and full-rate sweep phases",
             cfg_writes);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #(10_000_000);
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/fctg_pkg.sv
sv/fctg_cfg_regs.sv
sv/fctg_core.sv
sv/fctg_result_reg.sv
sv/four_channel_compare_tick_generator_unit.sv
sv/fctg_checker.sv
verif/four_channel_compare_tick_generator_unit_tb.sv
